@@ rtl/core/b32enc_pkg.sv @@
// Shared types and the 5-bit group to character mapping for the base32 encoder.
// Used by b32enc_ingest, b32enc_emit and base32_byte_to_text_encoder.
package b32enc_pkg;

	localparam int unsigned GroupBits = 5;
	localparam int unsigned WordBits  = 3 * GroupBits;  // up to three groups per byte
	localparam int unsigned CharBits  = 7;

	localparam logic [6:0] ChDigitLo = 7'd50;  // '2'
	localparam logic [6:0] ChDigitHi = 7'd57;  // '9'
	localparam logic [6:0] ChLetterI = 7'd73;  // 'I'
	localparam logic [6:0] ChLetterO = 7'd79;  // 'O'
	localparam logic [6:0] DigitToA  = 7'd7;   // jump from ':' up to 'A'

	// One ingested byte, left-aligned with its leftover bits, waiting to be drained.
	typedef struct packed {
		logic                valid;
		logic [WordBits-1:0] word;   // groups MSB first, zero padded on the right
		logic [1:0]          nchar;  // characters to emit, 1..3
		logic                last;   // message ends with this item
	} item_t;

	function automatic logic [CharBits-1:0] symbol_of(input logic [GroupBits-1:0] v);
		logic [6:0] c;
		c = {2'b00, v} + ChDigitLo;
		if (c > ChDigitHi) c = c + DigitToA;
		if (c >= ChLetterI) c = c + 7'd1;
		if (c >= ChLetterO) c = c + 7'd1;
		return c;
	endfunction

endpackage

@@ rtl/core/b32enc_ingest.sv @@
// Input stage: merges the byte with leftover bits and registers the aligned item.
// Depends on b32enc_pkg.
module b32enc_ingest (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] data_byte
	input  logic                   s_tlast,   // last_byte
	input  logic                   done,      // item fully drained this cycle
	output b32enc_pkg::item_t      item
);

	logic [3:0]  leftover_bits_q;
	logic [2:0]  leftover_count_q;

	logic                              valid_s1;
	logic [b32enc_pkg::WordBits-1:0]   word_s1;
	logic [1:0]                        nchar_s1;
	logic                              last_s1;

	logic [3:0]  lb_mask;
	logic [11:0] acc;
	logic [2:0]  shamt;
	logic        two_full;
	logic [2:0]  rem;
	logic        pad;
	logic        accept;

	always_comb begin
		unique case (leftover_count_q)
			3'd0:    lb_mask = 4'b0000;
			3'd1:    lb_mask = 4'b0001;
			3'd2:    lb_mask = 4'b0011;
			3'd3:    lb_mask = 4'b0111;
			default: lb_mask = 4'b1111;
		endcase
	end

	assign acc      = {leftover_bits_q & lb_mask, s_tdata};
	// total bits = count + 8 (8..12); shift by 15 - total = 7 - count
	assign shamt    = 3'd7 - leftover_count_q;
	assign two_full = (leftover_count_q >= 3'd2);
	assign rem      = two_full ? (leftover_count_q - 3'd2) : (leftover_count_q + 3'd3);
	assign pad      = s_tlast && (rem != 3'd0);

	assign s_tready = !valid_s1 || done;
	assign accept   = s_tvalid && s_tready;
	assign item     = '{valid: valid_s1, word: word_s1, nchar: nchar_s1, last: last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_bits_q  <= 4'd0;
			leftover_count_q <= 3'd0;
		end else if (accept) begin
			leftover_bits_q  <= s_tlast ? 4'd0 : acc[3:0];
			leftover_count_q <= s_tlast ? 3'd0 : rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1  <= {3'b000, acc} << shamt;
			nchar_s1 <= (two_full ? 2'd2 : 2'd1) + {1'b0, pad};
			last_s1  <= s_tlast;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		leftover_count_q <= 3'd4)
		else $error("leftover count above four");

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !done |=> valid_s1 && $stable(word_s1)
			&& $stable(nchar_s1))
		else $error("pending item changed before drained");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> leftover_count_q == 3'd0)
		else $error("leftover bits kept past end of message");

endmodule

@@ rtl/core/b32enc_emit.sv @@
// Output stage: drains one character per cycle, unless m_tready stalls it, from
// the pending item into the output register. Depends on b32enc_pkg.
module b32enc_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  b32enc_pkg::item_t      item,
	output logic                   done,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,   // [6:0] out_char, [7] zero
	output logic                   m_tlast    // last_char
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       last_q;

	logic                          load;
	logic                          final_of_item;
	logic [b32enc_pkg::GroupBits-1:0] group;

	always_comb begin
		unique case (idx_q)
			2'd0:    group = item.word[14:10];
			2'd1:    group = item.word[9:5];
			default: group = item.word[4:0];
		endcase
	end

	assign load          = item.valid && (!valid_q || m_tready);
	assign final_of_item = (idx_q == (item.nchar - 2'd1));
	assign done          = load && final_of_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= final_of_item ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= b32enc_pkg::symbol_of(group);
			last_q <= item.last && final_of_item;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid |-> idx_q < item.nchar)
		else $error("character index beyond item length");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!item.valid |-> idx_q == 2'd0)
		else $error("character index not reset between items");

endmodule

@@ rtl/core/base32_byte_to_text_encoder.sv @@
// Top level of the base32 byte-to-text encoder.
// Instantiates b32enc_ingest and b32enc_emit; depends on b32enc_pkg.
//
// Usage:
//   Slave stream (s_*): one raw byte per transaction, s_tlast marks the final
//   byte of a message. Master stream (m_*): one ASCII character per
//   transaction from the alphabet 2-9, A-Z without I and O; m_tlast marks the
//   final character of the message (the zero-padded one if bits remained).
//   Each byte yields one or two characters, up to three on the last byte.
// Flow: an accepted byte is registered in the input stage; its characters then
//   move one by one into the single output register.
// Throughput: one character per cycle unless m_tready stalls the output; a byte
//   occupies the input register until all its characters (1 to 3) have moved
//   out. The next byte is accepted in the cycle its predecessor's final character
//   moves to the output register, so bytes flow back to back.
// Reset: arst_n clears the leftover bits, the pending item and the output
//   valid; the next byte starts a new message.
// Stall: while m_tready is low the output character holds, the pending byte
//   waits in the input register and s_tready drops until it can drain.
module base32_byte_to_text_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
	output logic       m_tlast    // last_char
);

	// pending item handed from the input stage to the drain stage
	b32enc_pkg::item_t item;
	// pulses when the drain stage moves the item's final character out
	logic              done;

	b32enc_ingest u_ingest (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.done     (done),
		.item     (item)
	);

	b32enc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.done     (done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for base32_byte_to_text_encoder.
// Feeds byte messages over the slave stream and checks every character on the
// master stream. Depends on the DUT top level only (b32enc_pkg comes in with it).
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 200000;   // the run fails as a timeout once the cycle count passes this
	localparam int DRAIN_WAIT  = 20;       // cycles to watch for stray characters at the end
	localparam int LONG_HOLD   = 300;      // receiver back-pressure stretch
	localparam int HOLD_AT     = 40;       // start that stretch after this many characters
	localparam int RAND_BYTES  = 350;

	// One byte waiting to go out on the slave stream.
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain_first;   // hold until every expected character has arrived
	} msg_byte_t;

	// One character the encoder owes us.
	typedef struct {
		logic [6:0] ch;
		logic       last;
	} enc_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;    // [7:0] data_byte
	logic       s_tlast = 1'b0;     // last_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [6:0] out_char, [7] zero
	logic       m_tlast;            // last_char

	msg_byte_t byte_q[$];    // stimulus not yet offered
	enc_char_t char_q[$];    // characters predicted but not yet seen

	// Encoder shadow state: unconsumed bits (right-aligned) and how many.
	int unsigned carry_bits = 0;
	int          carry_cnt  = 0;

	int    errors = 0;
	int    cycles = 0;
	string char_set = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ";

	base32_byte_to_text_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d characters still expected", $realtime, char_q.size());
			$display("base32_byte_to_text_encoder test failed");
			$finish;
		end
	end

	// Shadow encoder: append 8 bits to the carry, peel off 5-bit groups MSB
	// first; on the last byte zero-pad any remainder into one more character
	// and restart the message.
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		int unsigned acc;
		int          cnt;
		logic [4:0]  grp;
		acc = (carry_bits << 8) | b;
		cnt = carry_cnt + 8;
		while (cnt >= 5) begin
			cnt -= 5;
			grp = 5'((acc >> cnt) & 31);
			acc &= (1 << cnt) - 1;
			// an exact fit leaves no pad, so this group closes the message
			char_q.push_back('{7'(char_set[grp]), fin && (cnt == 0)});
		end
		if (fin) begin
			if (cnt > 0) begin
				grp = 5'((acc << (5 - cnt)) & 31);
				char_q.push_back('{7'(char_set[grp]), 1'b1});
			end
			carry_bits = 0;
			carry_cnt  = 0;
		end else begin
			carry_bits = acc;
			carry_cnt  = cnt;
		end
	endtask

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// ---------------------------------------------------------------------
	// Driver. A transaction completes at an edge where s_tvalid and s_tready
	// were both high; the shadow encoder runs right then. A new byte is only
	// put up when the bus is empty or the previous one just went through.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : drv
		static int gap_left = 0;
		static int sent = 0;
		static bit quiet = 1'b0;   // no gaps while set
		msg_byte_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				encode_byte(s_tdata, s_tlast);
				sent++;
				if (sent % 40 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				gap_left = quiet ? 0 : pick_gap();
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					s_tvalid <= 1'b0;
					gap_left--;
				end else if (byte_q.size() != 0 &&
				             (!byte_q[0].drain_first || char_q.size() == 0)) begin
					nxt = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.data;
					s_tlast  <= nxt.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor. Checks each character transaction against the oldest
	// prediction, then decides m_tready for the next cycle: random stalls,
	// quiet stretches with none, and one long hold-off that backs the
	// encoder up into its input.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : mon
		static int got = 0;
		static int hold_left = 0;
		static int stall_left = 0;
		static bit quiet = 1'b0;
		enc_char_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got++;
				if (char_q.size() == 0) begin
					$display("%0t: unexpected character, expected none, actual data %h last %b",
					         $realtime, m_tdata, m_tlast);
					errors++;
				end else begin
					want = char_q.pop_front();
					if (m_tdata !== {1'b0, want.ch}) begin
						$display("%0t: out_char mismatch, expected %h, actual %h",
						         $realtime, {1'b0, want.ch}, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_char mismatch, expected %b, actual %b",
						         $realtime, want.last, m_tlast);
						errors++;
					end
				end
				if (got == HOLD_AT)
					hold_left = LONG_HOLD;
			end
			if (cycles % 128 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 20)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
					                                         : $urandom_range(1, 3);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of test.
	// ---------------------------------------------------------------------
	initial begin : stim
		logic [39:0] word;
		int          total;
		int          len;
		bit          pause;

		// Four 5-byte messages whose groups run 0..31 in order: every
		// alphabet entry, and the exact-fit end where no pad is added.
		for (int base = 0; base < 32; base += 8) begin
			word = '0;
			for (int k = 0; k < 8; k++)
				word = (word << 5) | 40'(base + k);
			for (int i = 0; i < 5; i++)
				byte_q.push_back('{word[39 - 8*i -: 8], i == 4, 1'b0});
		end
		// Single-byte messages at the extremes (3 bits padded).
		byte_q.push_back('{8'h00, 1'b1, 1'b0});
		byte_q.push_back('{8'hFF, 1'b1, 1'b0});
		// Two bytes: three groups and a 1-bit pad.
		byte_q.push_back('{8'hA5, 1'b0, 1'b0});
		byte_q.push_back('{8'h3C, 1'b1, 1'b0});

		// Random messages, mostly short, some long. The first one (and a few
		// more) waits for the encoder to empty before it starts.
		total = 0;
		pause = 1'b1;
		while (total < RAND_BYTES) begin
			len = $urandom_range(0, 99);
			if (len < 5)       len = 1;
			else if (len < 75) len = $urandom_range(1, 8);
			else               len = $urandom_range(9, 20);
			if (total + len > RAND_BYTES)
				len = RAND_BYTES - total;
			for (int i = 0; i < len; i++)
				byte_q.push_back('{8'($urandom_range(0, 255)), i == len - 1,
				                   pause && i == 0});
			total += len;
			pause = ($urandom_range(0, 99) < 6);
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// All bytes taken, then all characters back, then a short watch.
		// Checked at the falling edge, once the driver's updates have settled.
		do @(negedge clk); while (byte_q.size() != 0 || s_tvalid);
		do @(negedge clk); while (char_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0 && char_q.size() == 0)
			$display("base32_byte_to_text_encoder test passed");
		else
			$display("base32_byte_to_text_encoder test failed");
		$finish;
	end

endmodule
